// ----- rtl/pit_pkg.sv -----
package pit_pkg;

  // Operation codes carried by each request.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Register byte offsets.
  localparam logic [11:0] OFS_COUNT  = 12'h000;
  localparam logic [11:0] OFS_PERIOD = 12'h004;
  localparam logic [11:0] OFS_ENABLE = 12'h008;
  localparam logic [11:0] OFS_CLEAR  = 12'h00C;

  localparam int unsigned COUNT_W  = 64;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned IDX_W    = $clog2(COUNT_W);
  localparam logic [IDX_W-1:0] DIV_FIRST_IDX = IDX_W'(COUNT_W - 1);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_req;
    logic div_last;
  } sts_t;

endpackage

// ----- rtl/pit_ctrl.sv -----
module pit_ctrl
  import pit_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.div_step  = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = out_valid_r && out_stall;
      ST_DIV:  cmd.div_step = 1'b1;
      default: in_stall = 1'b1;
    endcase
    cmd.accept    = in_valid && !in_stall;
    cmd.div_start = cmd.accept && sts.div_req;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // No request may enter while the remainder is being worked out.
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !cmd.accept)
    else $error("request accepted during remainder division");

  a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == ST_DIV))
    else $error("division start did not enter the divide state");

  a_last_leaves_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && sts.div_last |=> (state_r == ST_IDLE))
    else $error("divide state not left after the last step");

endmodule

// ----- rtl/pit_datapath.sv -----
module pit_datapath
  import pit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_opcode,
  input  logic [11:0] in_offset,
  input  logic [31:0] in_write_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [31:0] out_read_data,
  output logic        out_bad_offset,
  output logic        out_irq_pending
);

  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                enabled_r, enabled_nxt;
  logic                pending_r, pending_nxt;
  logic [PERIOD_W-1:0] residue_r, residue_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [31:0]         rd_r, rd_nxt;
  logic                bad_r, bad_nxt;
  logic                irq_r;

  logic [PERIOD_W:0]   rem_sh;
  logic [PERIOD_W-1:0] rem_sub;
  logic [PERIOD_W-1:0] rem_step;
  logic [PERIOD_W-1:0] residue_inc;
  op_t                 op;

  assign op = op_t'(in_opcode);

  // One restoring step of count mod period, most significant bit first.
  // The difference is only taken when it is below the period, so its low
  // bits are all that is needed.
  assign rem_sh   = {rem_r, count_r[idx_r]};
  assign rem_sub  = rem_sh[PERIOD_W-1:0] - period_r;
  assign rem_step = (rem_sh >= {1'b0, period_r}) ? rem_sub
                                                 : rem_sh[PERIOD_W-1:0];

  assign residue_inc = residue_r + PERIOD_W'(1);

  assign sts.div_req  = (op == OP_WRITE) && (in_offset == OFS_PERIOD) &&
                        (in_write_data != 32'd0);
  assign sts.div_last = (idx_r == '0);

  always_comb begin
    count_nxt   = count_r;
    period_nxt  = period_r;
    enabled_nxt = enabled_r;
    pending_nxt = pending_r;
    residue_nxt = residue_r;
    rem_nxt     = rem_r;
    idx_nxt     = idx_r;
    rd_nxt      = 32'd0;
    bad_nxt     = 1'b0;

    if (cmd.accept) begin
      case (op)
        OP_READ: begin
          case (in_offset)
            OFS_COUNT:  rd_nxt = count_r[31:0];
            OFS_PERIOD: rd_nxt = period_r;
            OFS_ENABLE: rd_nxt = {31'd0, enabled_r};
            OFS_CLEAR:  rd_nxt = 32'd0;
            default:    bad_nxt = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (in_offset)
            OFS_COUNT: begin
            end
            OFS_PERIOD: begin
              period_nxt  = in_write_data;
              residue_nxt = '0;
            end
            OFS_ENABLE: enabled_nxt = in_write_data[0];
            OFS_CLEAR:  pending_nxt = 1'b0;
            default:    bad_nxt = 1'b1;
          endcase
        end
        OP_TICK: begin
          if (enabled_r) begin
            count_nxt = count_r + COUNT_W'(1);
            if (&count_r) begin
              // Wrap to zero, which is a multiple of every period.
              residue_nxt = '0;
              if (period_r != '0) begin
                pending_nxt = 1'b1;
              end
            end else if (period_r != '0) begin
              if (residue_inc == period_r) begin
                residue_nxt = '0;
                pending_nxt = 1'b1;
              end else begin
                residue_nxt = residue_inc;
              end
            end
          end
        end
        OP_CLEAR: pending_nxt = 1'b0;
        default: begin
        end
      endcase
    end

    if (cmd.div_start) begin
      rem_nxt = '0;
      idx_nxt = DIV_FIRST_IDX;
    end else if (cmd.div_step) begin
      rem_nxt = rem_step;
      idx_nxt = idx_r - IDX_W'(1);
      if (sts.div_last) begin
        residue_nxt = rem_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      period_r  <= '0;
      enabled_r <= 1'b0;
      pending_r <= 1'b0;
      residue_r <= '0;
    end else begin
      count_r   <= count_nxt;
      period_r  <= period_nxt;
      enabled_r <= enabled_nxt;
      pending_r <= pending_nxt;
      residue_r <= residue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
    if (cmd.accept) begin
      rd_r  <= rd_nxt;
      bad_r <= bad_nxt;
      irq_r <= pending_nxt;
    end
  end

  assign out_read_data   = rd_r;
  assign out_bad_offset  = bad_r;
  assign out_irq_pending = irq_r;

endmodule

// ----- rtl/periodic_interval_timer.sv -----
// A result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle unless a result waits on a stalling receiver;
// a write of a nonzero period holds off further requests while the new residue
// is found by a one-bit-per-cycle restoring divider.
// Reset (synchronous, active low) clears count, period, enable, pending flag
// and residue at once; there is no clearing pass.
module periodic_interval_timer
  import pit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [11:0] in_offset,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_bad_offset,
  output logic        out_irq_pending
);

  // The timer keeps the tick count modulo the period as a running residue,
  // so a tick needs only an increment and an equality compare rather than a
  // full 64-by-32 remainder. When the 64-bit count wraps to zero the residue
  // restarts at zero as well, since zero is a multiple of any period.
  //
  // Changing the period invalidates the residue. A write of a nonzero period
  // therefore hands the current count to a restoring divider that produces
  // one remainder bit per cycle over the 64 count bits. The result of that write
  // request is delivered straight away, and further requests are held off
  // until the new residue is in place. Ticks cannot arrive meanwhile, so the
  // count stays steady under the divider.
  //
  // The output register separates the two sides: a new request is taken
  // while the previous result is being collected, and held off only when a
  // result is waiting and the receiver is stalling, or while the divider runs.

  cmd_t cmd;
  sts_t sts;

  pit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pit_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_offset       (in_offset),
    .in_write_data   (in_write_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_read_data   (out_read_data),
    .out_bad_offset  (out_bad_offset),
    .out_irq_pending (out_irq_pending)
  );

endmodule
